FILE: sv/fdsd_pkg.sv
// fdsd_pkg: beat types, digit types, range limits and the segment table
// for the four-digit seven-segment driver; no dependencies
`default_nettype none

package fdsd_pkg;

  localparam int unsigned DigitCount = 4;
  localparam int unsigned BeatW      = $clog2(DigitCount);

  // range limits, inputs above these saturate
  localparam logic [13:0] RpmMax   = 14'd9999;
  localparam logic [6:0]  SpeedMax = 7'd99;

  // reciprocal multipliers, q = (x * m) >> s, exact over the saturated range
  localparam logic [14:0] RecipThou  = 15'd16778;  // 2^24 / 1000, rounded up
  localparam int unsigned ShiftThou  = 24;
  localparam logic [13:0] RecipHund  = 14'd10486;  // 2^20 / 100, rounded up
  localparam int unsigned ShiftHund  = 20;
  localparam logic [6:0]  RecipTen   = 7'd103;     // 2^10 / 10, rounded up
  localparam int unsigned ShiftTen   = 10;

  localparam logic [7:0] BlankPattern = 8'h7f;

  typedef struct packed {
    logic [13:0] engine_rpm;
    logic [6:0]  vehicle_speed;
    logic        toggle_call_led;
    logic        blank_all;
  } in_t;

  typedef struct packed {
    logic [3:0] digit_enable;
    logic [7:0] segment_byte;
    logic       last_digit;
  } out_t;

  // decimal digits of one item, in display order
  typedef struct packed {
    logic [3:0] rpm_thou;
    logic [3:0] rpm_hund;
    logic [3:0] spd_tens;
    logic [3:0] spd_unit;
  } digits_t;

  // active-low segments a..g for one decimal digit
  function automatic logic [6:0] seg_pattern(input logic [3:0] d);
    logic [6:0] p;
    case (d)
      4'd0:    p = 7'h40;
      4'd1:    p = 7'h79;
      4'd2:    p = 7'h24;
      4'd3:    p = 7'h30;
      4'd4:    p = 7'h19;
      4'd5:    p = 7'h12;
      4'd6:    p = 7'h02;
      4'd7:    p = 7'h78;
      4'd8:    p = 7'h00;
      4'd9:    p = 7'h10;
      default: p = 7'h7f;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

FILE: sv/fdsd_digit_split.sv
// fdsd_digit_split: saturates both speeds and splits them into four decimal
// digits with reciprocal multiplies; uses fdsd_pkg
`default_nettype none

module fdsd_digit_split (
  input  wire fdsd_pkg::in_t item,
  output fdsd_pkg::digits_t  digits
);

  logic [13:0] rpm_sat;
  logic [6:0]  spd_sat;
  logic [28:0] p_thou;
  logic [27:0] p_hund;
  logic [13:0] p_ten;
  logic [3:0]  q_thou;
  logic [6:0]  q_hund;
  logic [3:0]  q_ten;
  logic [6:0]  hund_diff;
  logic [6:0]  unit_diff;

  assign rpm_sat = (item.engine_rpm > fdsd_pkg::RpmMax) ? fdsd_pkg::RpmMax
                                                        : item.engine_rpm;
  assign spd_sat = (item.vehicle_speed > fdsd_pkg::SpeedMax) ? fdsd_pkg::SpeedMax
                                                             : item.vehicle_speed;

  // three independent multiplies, none feeds another
  assign p_thou = {15'd0, rpm_sat} * {14'd0, fdsd_pkg::RecipThou};
  assign p_hund = {14'd0, rpm_sat} * {14'd0, fdsd_pkg::RecipHund};
  assign p_ten  = {7'd0, spd_sat} * {7'd0, fdsd_pkg::RecipTen};

  assign q_thou = p_thou[fdsd_pkg::ShiftThou +: 4];
  assign q_hund = p_hund[fdsd_pkg::ShiftHund +: 7];
  assign q_ten  = p_ten[fdsd_pkg::ShiftTen +: 4];

  // digit = quotient minus ten times the next coarser quotient
  assign hund_diff = q_hund - ({q_thou, 3'b000} + {2'b00, q_thou, 1'b0});
  assign unit_diff = spd_sat - ({q_ten, 3'b000} + {2'b00, q_ten, 1'b0});

  assign digits.rpm_thou = q_thou;
  assign digits.rpm_hund = hund_diff[3:0];
  assign digits.spd_tens = q_ten;
  assign digits.spd_unit = unit_diff[3:0];

endmodule

`default_nettype wire

FILE: sv/four_digit_seven_segment_driver_core.sv
// four_digit_seven_segment_driver_core: top level, input register, digit
// frame register and beat sequencer; uses fdsd_pkg and fdsd_digit_split
`default_nettype none

// Each accepted input beat carries an engine speed and a vehicle speed and
// produces four output beats, one per display: rpm thousands, rpm hundreds,
// speed tens, speed units, each with a one-hot digit enable and an active-low
// segment byte whose bit 7 is the call LED. Speeds above range saturate to
// 9999 and 99. A set toggle flag flips the call LED before the item is shown,
// also when the item is blanked; a blanked item shows 0x7f on all digits.
// Timing: the input beat lands in an input register; from there the digits
// are split and encoded into a four-byte frame register once that register
// is empty or sending its last beat, and the frame's four beats leave one per
// cycle from there while out_ready is high. With out_ready held high the
// block takes input beats at the pace set by the four-beat drain of the
// frame register; the input register takes the next item while a frame is
// still draining, and the two registers part the two sides so that a stalled
// output never drops or repeats a beat.
module four_digit_seven_segment_driver_core (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire fdsd_pkg::in_t  in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output fdsd_pkg::out_t      out_data
);

  localparam int unsigned BeatW = fdsd_pkg::BeatW;
  localparam logic [BeatW-1:0] LastBeat = BeatW'(fdsd_pkg::DigitCount - 1);

  // input register
  logic           s1_valid_r, s1_valid_nxt;
  fdsd_pkg::in_t  s1_data_r;

  // frame register, one segment byte per digit, and beat counter
  logic             frm_valid_r, frm_valid_nxt;
  logic [BeatW-1:0] beat_r, beat_nxt;
  logic [7:0]       seg_r [fdsd_pkg::DigitCount];
  logic [7:0]       seg_nxt [fdsd_pkg::DigitCount];

  logic call_led_r, call_led_nxt;

  fdsd_pkg::digits_t digits;
  logic in_fire, out_fire, frm_done, frm_load;

  fdsd_digit_split u_split (
    .item   (s1_data_r),
    .digits (digits)
  );

  // handshake bookkeeping
  assign out_valid = frm_valid_r;
  assign out_fire  = out_valid && out_ready;
  assign frm_done  = out_fire && (beat_r == LastBeat);
  assign frm_load  = s1_valid_r && (!frm_valid_r || frm_done);
  assign in_ready  = !s1_valid_r || frm_load;
  assign in_fire   = in_valid && in_ready;

  // led flips as the item moves into the frame, in item order
  assign call_led_nxt = call_led_r ^ (frm_load && s1_data_r.toggle_call_led);

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (frm_load) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    frm_valid_nxt = frm_valid_r;
    beat_nxt      = beat_r;
    if (frm_load) begin
      frm_valid_nxt = 1'b1;
      beat_nxt      = '0;
    end else if (frm_done) begin
      frm_valid_nxt = 1'b0;
    end else if (out_fire) begin
      beat_nxt = beat_r + 1'b1;
    end
  end

  // encode the four digits, blanking overrides digit and led
  always_comb begin
    if (s1_data_r.blank_all) begin
      for (int i = 0; i < fdsd_pkg::DigitCount; i++) begin
        seg_nxt[i] = fdsd_pkg::BlankPattern;
      end
    end else begin
      seg_nxt[0] = {call_led_nxt, fdsd_pkg::seg_pattern(digits.rpm_thou)};
      seg_nxt[1] = {call_led_nxt, fdsd_pkg::seg_pattern(digits.rpm_hund)};
      seg_nxt[2] = {call_led_nxt, fdsd_pkg::seg_pattern(digits.spd_tens)};
      seg_nxt[3] = {call_led_nxt, fdsd_pkg::seg_pattern(digits.spd_unit)};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      frm_valid_r <= 1'b0;
      beat_r      <= '0;
      call_led_r  <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      frm_valid_r <= frm_valid_nxt;
      beat_r      <= beat_nxt;
      call_led_r  <= call_led_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_data_r <= in_data;
    end
    if (frm_load) begin
      for (int i = 0; i < fdsd_pkg::DigitCount; i++) begin
        seg_r[i] <= seg_nxt[i];
      end
    end
  end

  // output beat straight from the frame register
  assign out_data.digit_enable = 4'b0001 << beat_r;
  assign out_data.segment_byte = seg_r[beat_r];
  assign out_data.last_digit   = (beat_r == LastBeat);

  // a non-final beat taken is followed by the next digit of the same frame
  a_beat_advance: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire && !out_data.last_digit |=> out_valid &&
      (out_data.digit_enable == ($past(out_data.digit_enable) << 1)))
    else $error("digit sequence broken within a frame");

  // a drained frame with nothing waiting leaves the output idle
  a_frame_empty: assert property (@(posedge clk) disable iff (!rst_n)
    frm_done && !frm_load |=> !out_valid)
    else $error("output valid without a loaded frame");

  // the led only changes when an item enters the frame
  a_led_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !frm_load |=> $stable(call_led_r))
    else $error("call led changed outside a frame load");

  // the led bit never rides on a blank pattern
  a_blank_no_led: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.segment_byte[7] |-> out_data.segment_byte[6:0] != 7'h7f)
    else $error("led bit set on a blanked digit");

endmodule

`default_nettype wire
